@@ design/assert_macros.svh @@
// Assertion macros for the tokenizer modules; only mbt_queue uses them.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ design/mbt_pkg.sv @@
// Types and constants of the multipart body tokenizer.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mbt_pkg;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int BOUNDARY_REGS  = 7;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUNDARY_LENGTH = 4'd0;

    localparam logic [2:0] KIND_PART_OPEN  = 3'd0;
    localparam logic [2:0] KIND_HDR_NAME   = 3'd1;
    localparam logic [2:0] KIND_HDR_VALUE  = 3'd2;
    localparam logic [2:0] KIND_PARAM_NAME = 3'd3;
    localparam logic [2:0] KIND_PARAM_VAL  = 3'd4;
    localparam logic [2:0] KIND_DATA       = 3'd5;
    localparam logic [2:0] KIND_PART_CLOSE = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam int DATA_GAP = 4;

    typedef enum logic [2:0] {
        ST_FIND  = 3'd0,
        ST_HNAME = 3'd1,
        ST_HVAL  = 3'd2,
        ST_PNAME = 3'd3,
        ST_PVAL  = 3'd4,
        ST_DATA  = 3'd5,
        ST_SKIP  = 3'd6,
        ST_AFTER = 3'd7
    } parse_state_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic        last_token;
    } token_word_t;

    typedef struct packed {
        token_word_t first;
        token_word_t second;
        logic        two;
    } token_pair_t;

endpackage
`default_nettype wire

@@ design/multipart_body_tokenizer.sv @@
// Multipart body tokenizer top level: front classifier, bundle queue, output stage.
// Depends on mbt_pkg, mbt_front, mbt_queue and mbt_back.
//
// The block takes one body byte per clock and reports part open, header and
// parameter names and values, data and part close as offset and length tokens.
// The boundary compare over the whole window is done in the same cycle as the
// byte is taken, so a byte can enter every cycle. Tokens travel as bundles
// through a four-entry queue to the output register, which delivers one token
// per cycle while not stalled. A bundle holds two tokens only when a last-byte
// data flush follows another token from the same byte, which no parse path
// produces, so the input keeps one byte per clock while the output is not
// stalled. Output stalls back up through the queue, and the input stalls only
// while the queue is full. A token passes through the queue and then the output
// register before it is offered. There is no clearing pass after reset.
`default_nettype none
module multipart_body_tokenizer
    import mbt_pkg::*;
#(
    parameter int MAX_BOUNDARY = 56,
    parameter int OFFSET_BITS  = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      byte_valid,
    output logic                           byte_stall,
    input  wire byte_word_t                byte_word,
    output logic                           token_valid,
    input  wire logic                      token_stall,
    output token_word_t                    token_word,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    token_pair_t push_pair, head;
    logic        push, pop, not_empty, full, accept;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    mbt_front #(
        .MAX_BOUNDARY (MAX_BOUNDARY),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (byte_word),
        .pair      (push_pair),
        .push      (push)
    );

    mbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    mbt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule
`default_nettype wire

@@ design/mbt_front.sv @@
// Front part: boundary registers, match window and the header/data classifier.
// Depends on mbt_pkg; produces at most one bundle, of up to two tokens, per byte.
`default_nettype none
module mbt_front
    import mbt_pkg::*;
#(
    parameter int MAX_BOUNDARY = 56,
    parameter int OFFSET_BITS  = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      accept,
    input  wire byte_word_t                word,
    output token_pair_t                    pair,
    output logic                           push
);

    localparam int FILL_BITS = $clog2(MAX_BOUNDARY + 1);
    localparam int WIN_BITS  = MAX_BOUNDARY * 8;
    localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(MAX_BOUNDARY);
    localparam logic [OFFSET_BITS-1:0] GAP = OFFSET_BITS'(DATA_GAP);

    logic [WIN_BITS-1:0]     bnd_reg, bnd_next;
    logic [5:0]              blen_reg, blen_next;
    logic [FILL_BITS-1:0]    eff_reg, eff_next;
    logic [WIN_BITS-1:0]     aligned_reg, aligned_next;
    logic [MAX_BOUNDARY-1:0] mask_reg, mask_next;

    parse_state_t            state_reg, state_next;
    logic [OFFSET_BITS-1:0]  off_reg, off_next;
    logic [OFFSET_BITS-1:0]  sec_reg, sec_next;
    logic [OFFSET_BITS-1:0]  first_reg, first_next;
    logic [OFFSET_BITS-1:0]  last_reg, last_next;
    logic                    fq_reg, fq_next;
    logic                    lq_reg, lq_next;
    logic                    seen_reg, seen_next;
    logic                    swallow_reg, swallow_next;
    logic [WIN_BITS-1:0]     win_reg, win_next;
    logic [FILL_BITS-1:0]    fill_reg, fill_next;

    logic [7:0]              b;
    logic                    eol, is_sp, match;
    logic [WIN_BITS-1:0]     win_shift;
    logic [FILL_BITS-1:0]    fill_inc;
    logic [MAX_BOUNDARY-1:0] eq;
    logic [OFFSET_BITS-1:0]  o1, bstart, dlen;
    logic                    do_begin, do_track, main_v, flush_v;
    token_word_t             tok_main, tok_flush;

    function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

    function automatic token_word_t mk_tok(input logic [2:0] kind,
                                           input logic [OFFSET_BITS-1:0] start,
                                           input logic [OFFSET_BITS-1:0] len);
        token_word_t t;
        t.token_kind   = kind;
        t.token_start  = to32(start);
        t.token_length = to32(len);
        t.last_token   = 1'b0;
        return t;
    endfunction

    function automatic token_word_t trimmed(input logic [2:0] kind,
                                            input logic [OFFSET_BITS-1:0] o,
                                            input logic unquote,
                                            input logic seen,
                                            input logic [OFFSET_BITS-1:0] fst,
                                            input logic [OFFSET_BITS-1:0] lst,
                                            input logic fq,
                                            input logic lq);
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        start = o;
        len   = '0;
        if (seen)
        begin
            start = fst;
            len   = lst - fst + OFFSET_BITS'(1);
            if (unquote && fq && lq && (len >= OFFSET_BITS'(2)))
            begin
                start = start + OFFSET_BITS'(1);
                len   = len - OFFSET_BITS'(2);
            end
        end
        return mk_tok(kind, start, len);
    endfunction

    // Configuration writes, with the boundary aligned to the newest window bytes.
    generate
        for (genvar k = 0; k < MAX_BOUNDARY; k++)
        begin : g_bnd
            localparam int REG_SLOT = k / 8 + 1;
            if (REG_SLOT <= BOUNDARY_REGS)
            begin : g_wr
                always_comb
                begin
                    bnd_next[8*k +: 8] = bnd_reg[8*k +: 8];
                    if (cfg_write && (cfg_index == CFG_INDEX_BITS'(REG_SLOT)))
                    begin
                        bnd_next[8*k +: 8] = cfg_data[8*(k%8) +: 8];
                    end
                end
            end
            else
            begin : g_fixed
                assign bnd_next[8*k +: 8] = bnd_reg[8*k +: 8];
            end
        end
    endgenerate

    always_comb
    begin
        blen_next = blen_reg;
        if (cfg_write && (cfg_index == CFG_BOUNDARY_LENGTH))
        begin
            blen_next = cfg_data[5:0];
        end
        if (blen_next == 6'd0)
        begin
            eff_next = FILL_BITS'(1);
        end
        else if ({1'b0, blen_next} > 7'(MAX_BOUNDARY))
        begin
            eff_next = FILL_MAX;
        end
        else
        begin
            eff_next = FILL_BITS'(blen_next);
        end
        aligned_next = bnd_next << (8 * (FILL_MAX - eff_next));
        mask_next    = {MAX_BOUNDARY{1'b1}} << (FILL_MAX - eff_next);
    end

    always_comb
    begin
        b         = word.body_byte;
        eol       = (b == CH_CR) || (b == CH_LF);
        is_sp     = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        win_shift = {b, win_reg[WIN_BITS-1:8]};
        fill_inc  = (fill_reg == FILL_MAX) ? FILL_MAX : fill_reg + FILL_BITS'(1);
        for (int j = 0; j < MAX_BOUNDARY; j++)
        begin
            eq[j] = !mask_reg[j] || (win_shift[8*j +: 8] == aligned_reg[8*j +: 8]);
        end
        match  = (&eq) && (fill_inc >= eff_reg);
        o1     = off_reg + OFFSET_BITS'(1);
        bstart = o1 - OFFSET_BITS'(eff_reg);
        dlen   = bstart - sec_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        off_next     = o1;
        sec_next     = sec_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        fq_next      = fq_reg;
        lq_next      = lq_reg;
        seen_next    = seen_reg;
        swallow_next = swallow_reg;
        win_next     = win_shift;
        fill_next    = fill_inc;
        do_begin     = 1'b0;
        do_track     = 1'b0;
        main_v       = 1'b0;
        flush_v      = 1'b0;
        tok_main     = '0;
        tok_flush    = '0;

        if (swallow_reg && (b == CH_LF))
        begin
            swallow_next = 1'b0;
            do_begin     = 1'b1;
            if (state_reg == ST_DATA)
            begin
                fill_next = '0;
            end
        end
        else
        begin
            swallow_next = 1'b0;
            unique case (state_reg)
                ST_FIND:
                begin
                    if (match)
                    begin
                        main_v     = 1'b1;
                        tok_main   = mk_tok(KIND_PART_OPEN, bstart, '0);
                        state_next = ST_AFTER;
                    end
                end
                ST_AFTER:
                begin
                    swallow_next = (b == CH_CR);
                    do_begin     = 1'b1;
                    state_next   = ST_HNAME;
                end
                ST_HNAME:
                begin
                    if (eol)
                    begin
                        swallow_next = (b == CH_CR);
                        do_begin     = 1'b1;
                        fill_next    = '0;
                        state_next   = ST_DATA;
                    end
                    else if (b == CH_COLON)
                    begin
                        main_v     = 1'b1;
                        tok_main   = trimmed(KIND_HDR_NAME, off_reg, 1'b0, seen_reg,
                                             first_reg, last_reg, fq_reg, lq_reg);
                        do_begin   = 1'b1;
                        state_next = ST_HVAL;
                    end
                    else
                    begin
                        do_track = 1'b1;
                    end
                end
                ST_HVAL, ST_PVAL:
                begin
                    if (eol || (b == CH_SEMI))
                    begin
                        main_v       = 1'b1;
                        tok_main     = trimmed((state_reg == ST_PVAL) ? KIND_PARAM_VAL
                                                                      : KIND_HDR_VALUE,
                                               off_reg, state_reg == ST_PVAL, seen_reg,
                                               first_reg, last_reg, fq_reg, lq_reg);
                        swallow_next = (b == CH_CR);
                        do_begin     = 1'b1;
                        state_next   = eol ? ST_HNAME : ST_PNAME;
                    end
                    else
                    begin
                        do_track = 1'b1;
                    end
                end
                ST_PNAME:
                begin
                    if (eol)
                    begin
                        swallow_next = (b == CH_CR);
                        do_begin     = 1'b1;
                        state_next   = ST_HNAME;
                    end
                    else if (b == CH_EQUAL)
                    begin
                        main_v     = 1'b1;
                        tok_main   = trimmed(KIND_PARAM_NAME, off_reg, 1'b0, seen_reg,
                                             first_reg, last_reg, fq_reg, lq_reg);
                        do_begin   = 1'b1;
                        state_next = ST_PVAL;
                    end
                    else
                    begin
                        do_track = 1'b1;
                    end
                end
                ST_DATA:
                begin
                    if (match)
                    begin
                        main_v     = 1'b1;
                        tok_main   = mk_tok(KIND_DATA, sec_reg,
                                            (dlen < GAP) ? '0 : dlen - GAP);
                        state_next = ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    if (eol)
                    begin
                        main_v       = 1'b1;
                        tok_main     = mk_tok(KIND_PART_CLOSE, off_reg, '0);
                        swallow_next = (b == CH_CR);
                        do_begin     = 1'b1;
                        state_next   = ST_HNAME;
                    end
                end
            endcase
        end

        if (do_begin)
        begin
            sec_next   = o1;
            first_next = '0;
            last_next  = '0;
            fq_next    = 1'b0;
            lq_next    = 1'b0;
            seen_next  = 1'b0;
        end
        else if (do_track && !is_sp)
        begin
            if (!seen_reg)
            begin
                seen_next  = 1'b1;
                first_next = off_reg;
                fq_next    = (b == CH_QUOTE);
            end
            last_next = off_reg;
            lq_next   = (b == CH_QUOTE);
        end

        if (word.last_byte)
        begin
            if (state_next == ST_DATA)
            begin
                flush_v   = 1'b1;
                tok_flush = mk_tok(KIND_DATA, sec_next, o1 - sec_next);
            end
            state_next   = ST_FIND;
            off_next     = '0;
            sec_next     = '0;
            first_next   = '0;
            last_next    = '0;
            fq_next      = 1'b0;
            lq_next      = 1'b0;
            seen_next    = 1'b0;
            swallow_next = 1'b0;
            win_next     = '0;
            fill_next    = '0;
        end
    end

    always_comb
    begin
        pair.first  = main_v ? tok_main : tok_flush;
        pair.second = tok_flush;
        pair.two    = main_v && flush_v;
        pair.first.last_token  = !(main_v && flush_v);
        pair.second.last_token = 1'b1;
        push = accept && (main_v || flush_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg     <= '0;
            blen_reg    <= 6'd1;
            eff_reg     <= FILL_BITS'(1);
            aligned_reg <= '0;
            mask_reg    <= {MAX_BOUNDARY{1'b1}} << (MAX_BOUNDARY - 1);
            state_reg   <= ST_FIND;
            off_reg     <= '0;
            sec_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            fq_reg      <= 1'b0;
            lq_reg      <= 1'b0;
            seen_reg    <= 1'b0;
            swallow_reg <= 1'b0;
            win_reg     <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            bnd_reg     <= bnd_next;
            blen_reg    <= blen_next;
            eff_reg     <= eff_next;
            aligned_reg <= aligned_next;
            mask_reg    <= mask_next;
            if (accept)
            begin
                state_reg   <= state_next;
                off_reg     <= off_next;
                sec_reg     <= sec_next;
                first_reg   <= first_next;
                last_reg    <= last_next;
                fq_reg      <= fq_next;
                lq_reg      <= lq_next;
                seen_reg    <= seen_next;
                swallow_reg <= swallow_next;
                win_reg     <= win_next;
                fill_reg    <= fill_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/mbt_queue.sv @@
// Short queue of token bundles between the classifier and the output stage.
// Depends on mbt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mbt_queue
    import mbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire token_pair_t push_pair,
    input  wire logic        pop,
    output token_pair_t      head,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    token_pair_t         mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + PTR_BITS'(1) : wr_reg;
        rd_next  = pop ? rd_reg + PTR_BITS'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_BITS'(push) - CNT_BITS'(pop);
        head      = mem[rd_reg];
        not_empty = (cnt_reg != '0);
        full      = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEVER(a_push_full, clk, rst_n, push && full)
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !not_empty)
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, cnt_reg <= CNT_BITS'(QUEUE_DEPTH))
    `ASSERT_ALWAYS(a_ptr_track, clk, rst_n,
        (wr_reg - rd_reg) == PTR_BITS'(cnt_reg))

endmodule
`default_nettype wire

@@ design/mbt_back.sv @@
// Back part: splits token bundles and holds the output word register.
// Depends on mbt_pkg; pops a bundle as its last token is loaded.
`default_nettype none
module mbt_back
    import mbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire token_pair_t head,
    input  wire logic        not_empty,
    output logic             pop,
    output logic             token_valid,
    input  wire logic        token_stall,
    output token_word_t      token_word
);

    logic        valid_reg, valid_next;
    token_word_t word_reg, word_next;
    logic        phase_reg, phase_next;
    logic        load;

    always_comb
    begin
        load       = !valid_reg || !token_stall;
        valid_next = valid_reg;
        word_next  = word_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b0;
            if (phase_reg)
            begin
                valid_next = 1'b1;
                word_next  = head.second;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
            else if (not_empty)
            begin
                valid_next = 1'b1;
                word_next  = head.first;
                phase_next = head.two;
                pop        = !head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    assign token_valid = valid_reg;
    assign token_word  = word_reg;

endmodule
`default_nettype wire
